// ===== rtl/core/sample_accumulation_resolve_core_defines.svh =====
// Assertion helpers for the RTL.
`ifndef SAMPLE_ACCUMULATION_RESOLVE_CORE_DEFINES_SVH
`define SAMPLE_ACCUMULATION_RESOLVE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// a holds at an edge -> b holds at the same edge
`define SAR_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sar assertion failed");
// a holds at an edge -> b holds at the next edge
`define SAR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sar assertion failed");
`else
`define SAR_ASSERT_IMP(label, clk, rst, a, b)
`define SAR_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ===== rtl/core/sar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sar_pkg;

  localparam int MAX_PIXELS_DEF = 65536;
  localparam int ACC_BITS_DEF   = 40;
  localparam int CNT_BITS       = 32;
  localparam int QB             = 17;   // quotient bits, covers 0..131071
  localparam int IDX_BITS       = 17;   // x + y * width for 8-bit x, y and 9-bit width
  localparam int WIDTH_BITS     = 9;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 9'd256;

  localparam logic [1:0] MODE_ACC     = 2'd0;
  localparam logic [1:0] MODE_RESOLVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] RS_OK    = 2'd0;
  localparam logic [1:0] RS_EMPTY = 2'd1;
  localparam logic [1:0] RS_RANGE = 2'd2;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_INDEX, ST_ISSUE, ST_WAIT, ST_EXEC, ST_START,
    ST_DIV, ST_MUL, ST_SQINIT, ST_SQRT, ST_CHAN, ST_DONE
  } sar_state_t;

  typedef struct packed {
    logic       load_item;
    logic       calc_index;
    logic       ram_rd;
    logic       wr_acc;
    logic       wr_zero;
    logic       sweep_wr;
    logic       latch_word;
    logic       div_start;
    logic       div_step;
    logic       mul;
    logic       sq_init;
    logic       sq_step;
    logic       chan_store;
    logic       set_code;
    logic [1:0] code;
    logic       res_load;
  } sar_cmd_t;

  typedef struct packed {
    logic       in_bounds;
    logic [1:0] mode;
    logic       cnt_zero;
    logic       div_last;
    logic       sq_last;
    logic       ch_last;
    logic       sweep_last;
    logic       out_free;
  } sar_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/sar_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sar_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [23:0] red_sum_in;
  logic [23:0] green_sum_in;
  logic [23:0] blue_sum_in;
  logic [15:0] samples_in;

  modport source (output valid, mode, pixel_x, pixel_y, red_sum_in, green_sum_in,
                  blue_sum_in, samples_in, input ready);
  modport sink (input valid, mode, pixel_x, pixel_y, red_sum_in, green_sum_in,
                blue_sum_in, samples_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sar_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sar_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [1:0] resolve_status;

  modport source (output valid, red_out, green_out, blue_out, resolve_status,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, resolve_status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sar_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sar_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sar_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sar_pkg::sar_sts_t sts,
  output sar_pkg::sar_cmd_t      cmd
);
  import sar_pkg::*;

  sar_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP:  if (sts.sweep_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (!sts.in_bounds) begin
          state_next = (sts.mode == MODE_RESOLVE) ? ST_DONE : ST_IDLE;
        end else if (sts.mode inside {MODE_ACC, MODE_RESOLVE}) begin
          state_next = ST_WAIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WAIT:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (sts.mode == MODE_ACC) state_next = ST_IDLE;
        else if (sts.cnt_zero)    state_next = ST_DONE;
        else                      state_next = ST_START;
      end
      ST_START:  state_next = ST_DIV;
      ST_DIV:    if (sts.div_last) state_next = ST_MUL;
      ST_MUL:    state_next = ST_SQINIT;
      ST_SQINIT: state_next = ST_SQRT;
      ST_SQRT:   if (sts.sq_last) state_next = ST_CHAN;
      ST_CHAN:   state_next = sts.ch_last ? ST_DONE : ST_START;
      ST_DONE:   if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_SWEEP: cmd.sweep_wr = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_INDEX: cmd.calc_index = 1'b1;
      ST_ISSUE: begin
        if (!sts.in_bounds) begin
          cmd.set_code = (sts.mode == MODE_RESOLVE);
          cmd.code     = RS_RANGE;
        end else if (sts.mode inside {MODE_ACC, MODE_RESOLVE}) begin
          cmd.ram_rd = 1'b1;
        end else if (sts.mode == MODE_CLEAR) begin
          cmd.wr_zero = 1'b1;
        end
      end
      ST_WAIT: cmd.latch_word = 1'b1;
      ST_EXEC: begin
        if (sts.mode == MODE_ACC) begin
          cmd.wr_acc = 1'b1;
        end else if (sts.cnt_zero) begin
          cmd.set_code = 1'b1;
          cmd.code     = RS_EMPTY;
        end
      end
      ST_START:  cmd.div_start = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_MUL:    cmd.mul       = 1'b1;
      ST_SQINIT: cmd.sq_init   = 1'b1;
      ST_SQRT:   cmd.sq_step   = 1'b1;
      ST_CHAN: begin
        cmd.chan_store = 1'b1;
        cmd.set_code   = sts.ch_last;
        cmd.code       = RS_OK;
      end
      ST_DONE: cmd.res_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/sar_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sar_dp #(
  parameter int MAX_PIXELS = sar_pkg::MAX_PIXELS_DEF,
  parameter int ACC_BITS   = sar_pkg::ACC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sar_pkg::sar_cmd_t               cmd,
  output sar_pkg::sar_sts_t                    sts,
  input  wire logic [sar_pkg::WIDTH_BITS-1:0]  image_width,
  input  wire logic [1:0]                      mode,
  input  wire logic [7:0]                      pixel_x,
  input  wire logic [7:0]                      pixel_y,
  input  wire logic [23:0]                     red_sum_in,
  input  wire logic [23:0]                     green_sum_in,
  input  wire logic [23:0]                     blue_sum_in,
  input  wire logic [15:0]                     samples_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           red_out,
  output logic [7:0]                           green_out,
  output logic [7:0]                           blue_out,
  output logic [1:0]                           resolve_status
);
  import sar_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int WW = 3 * ACC_BITS + CNT_BITS;
  localparam int DW = (ACC_BITS > CNT_BITS + QB) ? ACC_BITS : CNT_BITS + QB;
  localparam logic [QB-1:0] ONE_Q16 = QB'(65536);

  // item registers
  logic [1:0]  mode_r;
  logic [7:0]  px_r, py_r;
  logic [23:0] rin_r, gin_r, bin_r;
  logic [15:0] sin_r;
  logic [IDX_BITS-1:0] idx_r, idx_next;
  logic        in_bounds_r;

  // pixel word
  logic [ACC_BITS-1:0] racc, gacc, bacc;
  logic [CNT_BITS-1:0] cnt;
  logic [WW-1:0]       rdata, wdata;
  logic [AW-1:0]       sweep_addr, addr;

  // divide / multiply / root
  logic [DW-1:0]       rem, dvs, sum_ext;
  logic [QB-1:0]       quo, qc;
  logic                over;
  logic [4:0]          dcnt;
  logic [32:0]         prod;
  logic [15:0]         tval, sv, root, sbit;
  logic [16:0]         trial;
  logic [2:0]          scnt;
  logic [1:0]          ch;
  logic [7:0]          chan [3];
  logic [1:0]          code;
  logic [ACC_BITS-1:0] sum_sel;
  logic [CNT_BITS:0]   cnt_sum;
  logic [CNT_BITS-1:0] cnt_sat;

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [23:0] b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + (ACC_BITS+1)'(b);
    return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= mode;
      px_r   <= pixel_x;
      py_r   <= pixel_y;
      rin_r  <= red_sum_in;
      gin_r  <= green_sum_in;
      bin_r  <= blue_sum_in;
      sin_r  <= samples_in;
    end
  end

  assign idx_next = IDX_BITS'(px_r) + IDX_BITS'(py_r) * IDX_BITS'(image_width);

  always_ff @(posedge clk) begin
    if (cmd.calc_index) begin
      idx_r       <= idx_next;
      in_bounds_r <= ({1'b0, px_r} < image_width) && (32'(idx_next) < 32'(MAX_PIXELS));
    end
  end

  // post-reset clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  assign cnt_sum = {1'b0, cnt} + (CNT_BITS+1)'(sin_r);
  assign cnt_sat = cnt_sum[CNT_BITS] ? {CNT_BITS{1'b1}} : cnt_sum[CNT_BITS-1:0];
  assign addr    = cmd.sweep_wr ? sweep_addr : AW'(idx_r);
  assign wdata   = cmd.wr_acc ? {cnt_sat, sat_add(bacc, bin_r), sat_add(gacc, gin_r),
                                 sat_add(racc, rin_r)} : '0;

  sar_ram #(.WIDTH(WW), .DEPTH(MAX_PIXELS)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_acc | cmd.wr_zero | cmd.sweep_wr),
    .re    (cmd.ram_rd),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_word) begin
      racc <= rdata[ACC_BITS-1:0];
      gacc <= rdata[2*ACC_BITS-1:ACC_BITS];
      bacc <= rdata[3*ACC_BITS-1:2*ACC_BITS];
      cnt  <= rdata[WW-1:3*ACC_BITS];
    end
  end

  always_comb begin
    case (ch)
      2'd0:    sum_sel = racc;
      2'd1:    sum_sel = gacc;
      default: sum_sel = bacc;
    endcase
  end
  assign sum_ext = DW'(sum_sel);

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= sum_ext;
      dvs  <= DW'(cnt) << (QB - 1);
      over <= sum_ext >= (DW'(cnt) << QB);
      quo  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        quo <= {quo[QB-2:0], 1'b0};
      end
      dvs  <= dvs >> 1;
      dcnt <= dcnt + 5'd1;
    end
  end

  assign qc   = (over || quo > ONE_Q16) ? ONE_Q16 : quo;
  assign prod = 33'(qc) * 33'(65025);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      tval <= prod[31:16];
    end
  end

  // integer square root, two radicand bits a cycle
  assign trial = {1'b0, root} + {1'b0, sbit};

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sv   <= tval;
      root <= '0;
      sbit <= 16'h4000;
      scnt <= '0;
    end else if (cmd.sq_step) begin
      if ({1'b0, sv} >= trial) begin
        sv   <= sv - trial[15:0];
        root <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
      scnt <= scnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ch <= '0;
    end else if (cmd.chan_store) begin
      chan[ch] <= root[7:0];
      ch       <= ch + 2'd1;
    end
    if (cmd.set_code) begin
      code <= cmd.code;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      red_out        <= (code == RS_OK) ? chan[0] : 8'd0;
      green_out      <= (code == RS_OK) ? chan[1] : 8'd0;
      blue_out       <= (code == RS_OK) ? chan[2] : 8'd0;
      resolve_status <= code;
    end
  end

  assign sts.in_bounds  = in_bounds_r;
  assign sts.mode       = mode_r;
  assign sts.cnt_zero   = (cnt == '0);
  assign sts.div_last   = (dcnt == 5'(QB - 1));
  assign sts.sq_last    = (scnt == 3'd7);
  assign sts.ch_last    = (ch == 2'd2);
  assign sts.sweep_last = (sweep_addr == AW'(MAX_PIXELS - 1));
  assign sts.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/core/sample_accumulation_resolve_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sample_accumulation_resolve_core_defines.svh"
// Per-pixel accumulation buffer with gamma-2 resolve. Each input word names a
// pixel (index pixel_x + pixel_y * image_width) and a mode: accumulate adds
// the Q8.16 color sums and the sample count with saturation, clear zeroes the
// pixel, resolve returns one output word of floor(255*sqrt(min(sum/count,1)))
// per channel with a status (ok, no samples, coordinate out of range).
// Items are handled one at a time: accumulate steps through index, RAM
// read, latch and write back; resolve uses one shared restoring divider
// and a 2-bit-per-cycle square root, run over the three channels in turn.
// After reset a clearing pass writes zero to all MAX_PIXELS entries, one
// per cycle, before the first item is accepted; APB writes are taken
// during it.
module sample_accumulation_resolve_core #(
  parameter int MAX_PIXELS = sar_pkg::MAX_PIXELS_DEF,
  parameter int ACC_BITS   = sar_pkg::ACC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sar_in_if.sink           in_ch,
  sar_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sar_pkg::*;

  sar_cmd_t cmd;
  sar_sts_t sts;
  logic [WIDTH_BITS-1:0] image_width;

  // config register: image_width at byte 0
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      image_width <= pwdata[WIDTH_BITS-1:0];
    end
  end
  assign prdata = (paddr == 3'd0) ? 32'(image_width) : 32'd0;

  sar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sar_dp #(.MAX_PIXELS(MAX_PIXELS), .ACC_BITS(ACC_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .image_width    (image_width),
    .mode           (in_ch.mode),
    .pixel_x        (in_ch.pixel_x),
    .pixel_y        (in_ch.pixel_y),
    .red_sum_in     (in_ch.red_sum_in),
    .green_sum_in   (in_ch.green_sum_in),
    .blue_sum_in    (in_ch.blue_sum_in),
    .samples_in     (in_ch.samples_in),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .red_out        (out_ch.red_out),
    .green_out      (out_ch.green_out),
    .blue_out       (out_ch.blue_out),
    .resolve_status (out_ch.resolve_status)
  );

  // one item in flight: no second accept right after one
  `SAR_ASSERT_NEXT(a_one_item, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  // status is always a defined code
  `SAR_ASSERT_IMP(a_status_code, clk, rst, out_ch.valid, (out_ch.resolve_status == RS_OK) || (out_ch.resolve_status == RS_EMPTY) || (out_ch.resolve_status == RS_RANGE))
  // error status carries black color
  `SAR_ASSERT_IMP(a_err_black, clk, rst, out_ch.valid && out_ch.resolve_status != RS_OK, out_ch.red_out == 8'd0 && out_ch.green_out == 8'd0 && out_ch.blue_out == 8'd0)

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import sar_pkg::*;

  localparam int NPIX      = 65536;
  localparam int CYC_LIMIT = 1000000;
  localparam int HOLD_CYC  = 400;   // long receiver stall, fills the block up
  localparam int DRAIN_CYC = 200;   // quiet time after the last owed word, allow plenty

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
  } color_word_t;

  // Shadow of the pixel store plus the queue of resolved colors still owed.
  class pixel_scoreboard;
    logic [WIDTH_BITS-1:0] row_width;
    logic [39:0] red_sum [NPIX];
    logic [39:0] green_sum [NPIX];
    logic [39:0] blue_sum [NPIX];
    logic [31:0] sample_cnt [NPIX];
    color_word_t owed[$];
    int errors;

    function new();
      row_width = WIDTH_RESET;
      errors = 0;
      for (int i = 0; i < NPIX; i++) begin
        red_sum[i] = '0;
        green_sum[i] = '0;
        blue_sum[i] = '0;
        sample_cnt[i] = '0;
      end
    endfunction

    function logic [39:0] sat_add(logic [39:0] acc, logic [23:0] add);
      logic [40:0] s;
      s = {1'b0, acc} + add;
      return s[40] ? '1 : s[39:0];
    endfunction

    // floor(255*sqrt(min(sum/cnt, 1.0))) in Q.16
    function logic [7:0] gamma_channel(logic [39:0] sum, logic [31:0] cnt);
      logic [63:0] q;
      logic [63:0] t;
      int c;
      q = sum / cnt;
      if (q > 64'd65536) q = 64'd65536;
      t = (64'd65025 * q) >> 16;
      c = 0;
      while (c < 255 && (c + 1) * (c + 1) <= t) c++;
      return c[7:0];
    endfunction

    function void note(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                       logic [23:0] r, logic [23:0] g, logic [23:0] b,
                       logic [15:0] s);
      logic [31:0] idx;
      logic in_range;
      logic [32:0] cnt;
      color_word_t w;
      idx = x + y * row_width;
      in_range = (x < row_width) && (idx < NPIX);
      w = '0;
      case (mode)
        MODE_ACC: begin
          if (in_range) begin
            red_sum[idx] = sat_add(red_sum[idx], r);
            green_sum[idx] = sat_add(green_sum[idx], g);
            blue_sum[idx] = sat_add(blue_sum[idx], b);
            cnt = sample_cnt[idx] + s;
            sample_cnt[idx] = cnt[32] ? '1 : cnt[31:0];
          end
        end
        MODE_CLEAR: begin
          if (in_range) begin
            red_sum[idx] = '0;
            green_sum[idx] = '0;
            blue_sum[idx] = '0;
            sample_cnt[idx] = '0;
          end
        end
        MODE_RESOLVE: begin
          if (!in_range) begin
            w.status = RS_RANGE;
          end else if (sample_cnt[idx] == 0) begin
            w.status = RS_EMPTY;
          end else begin
            w.red = gamma_channel(red_sum[idx], sample_cnt[idx]);
            w.green = gamma_channel(green_sum[idx], sample_cnt[idx]);
            w.blue = gamma_channel(blue_sum[idx], sample_cnt[idx]);
            w.status = RS_OK;
          end
          owed.push_back(w);
        end
        default: ;
      endcase
    endfunction

    function void check(color_word_t got);
      color_word_t exp_w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected color word %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = owed.pop_front();
      if (got.red !== exp_w.red)
        $display("%0t: red_out exp %0d got %0d", $realtime, exp_w.red, got.red);
      if (got.green !== exp_w.green)
        $display("%0t: green_out exp %0d got %0d", $realtime, exp_w.green, got.green);
      if (got.blue !== exp_w.blue)
        $display("%0t: blue_out exp %0d got %0d", $realtime, exp_w.blue, got.blue);
      if (got.status !== exp_w.status)
        $display("%0t: resolve_status exp %0d got %0d", $realtime, exp_w.status,
                 got.status);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sar_in_if in_ch ();
  sar_out_if out_ch ();

  sample_accumulation_resolve_core i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  pixel_scoreboard pixels = new();
  bit hold_req = 0;     // ask the receiver for one long stall
  bit send_burst = 0;   // stretches of back-to-back words
  bit recv_burst = 0;
  int cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ACC;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.red_sum_in = '0;
    in_ch.green_sum_in = '0;
    in_ch.blue_sum_in = '0;
    in_ch.samples_in = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog on the whole run, clearing pass after reset included.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Two-phase APB write; register lands at the access edge.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pixels.row_width = data[WIDTH_BITS-1:0];
  endtask

  task automatic send_word(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                           logic [23:0] r, logic [23:0] g, logic [23:0] b,
                           logic [15:0] s);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.pixel_x <= x;
    in_ch.pixel_y <= y;
    in_ch.red_sum_in <= r;
    in_ch.green_sum_in <= g;
    in_ch.blue_sum_in <= b;
    in_ch.samples_in <= s;
    do @(posedge clk); while (!in_ch.ready);
    pixels.note(mode, x, y, r, g, b, s);
  endtask

  // Block must be quiet before a register write: nothing owed, then a pause
  // long enough for a trailing accumulate or clear to finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pixels.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Mostly a small hot set of pixels so sums build up and get resolved;
  // the rest spans the whole coordinate range.
  task automatic random_word();
    logic [1:0] mode;
    logic [7:0] x, y;
    logic [23:0] r, g, b;
    logic [15:0] s;
    int pick;
    int w;
    pick = $urandom_range(0, 99);
    mode = pick < 45 ? MODE_ACC : pick < 82 ? MODE_RESOLVE : pick < 95 ? MODE_CLEAR : 2'd3;
    w = pixels.row_width == 0 ? 1 : pixels.row_width;
    if ($urandom_range(0, 4) != 0) begin
      x = $urandom_range(0, 1) ? $urandom_range(0, 3) : (w > 256 ? 255 : w - 1);
      y = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(250, 255);
      if ($urandom_range(0, 9) == 0) x = x + 1;   // just past the row end
    end else begin
      x = $urandom();
      y = $urandom();
    end
    case ($urandom_range(0, 3))
      0: begin r = $urandom(); g = $urandom(); b = $urandom(); end
      1: begin
        r = $urandom_range(0, 70000);
        g = $urandom_range(0, 70000);
        b = $urandom_range(0, 70000);
      end
      2: begin r = '1; g = '0; b = $urandom_range(0, 65536); end
      default: begin r = $urandom() >> $urandom_range(0, 23); g = r >> 1; b = $urandom(); end
    endcase
    case ($urandom_range(0, 5))
      0: s = 16'd0;
      1: s = 16'hFFFF;
      2: s = $urandom();
      default: s = $urandom_range(1, 8);
    endcase
    send_word(mode, x, y, r, g, b, s);
  endtask

  // Receiver: random stalls, back-to-back stretches, one long hold-off.
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 0;
      end else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      pixels.check({out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                    out_ch.resolve_status});
    end
  end

  initial begin
    logic [8:0] widths [6] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd37, 9'd200};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks at the reset width of 256.
    send_word(MODE_RESOLVE, 8'd0, 8'd0, '0, '0, '0, '0);              // never written
    send_word(MODE_ACC, 8'd0, 8'd0, '1, '1, '1, 16'd1);               // far above 1.0
    send_word(MODE_RESOLVE, 8'd0, 8'd0, '0, '0, '0, '0);              // clamps to 255
    send_word(MODE_ACC, 8'd1, 8'd0, 24'h010000, 24'h004000, 24'h0, 16'd0);
    send_word(MODE_RESOLVE, 8'd1, 8'd0, '0, '0, '0, '0);              // sums but no samples
    send_word(MODE_ACC, 8'd1, 8'd0, '0, '0, '0, 16'd1);
    send_word(MODE_RESOLVE, 8'd1, 8'd0, '0, '0, '0, '0);              // 1.0, 0.25, 0
    send_word(MODE_ACC, 8'd255, 8'd255, 24'h00FFFF, 24'h000001, 24'h123456, 16'hFFFF);
    send_word(MODE_RESOLVE, 8'd255, 8'd255, '0, '0, '0, '0);          // last pixel
    send_word(MODE_CLEAR, 8'd0, 8'd0, '0, '0, '0, '0);
    send_word(MODE_RESOLVE, 8'd0, 8'd0, '0, '0, '0, '0);              // cleared
    send_word(2'd3, 8'd1, 8'd0, '1, '1, '1, '1);                      // unused mode
    send_word(MODE_RESOLVE, 8'd1, 8'd0, '0, '0, '0, '0);              // unchanged
    drain();
    reg_write(3'd0, 32'd100);
    send_word(MODE_ACC, 8'd100, 8'd0, '1, '1, '1, 16'd1);             // x past row end
    send_word(MODE_RESOLVE, 8'd100, 8'd0, '0, '0, '0, '0);
    send_word(MODE_RESOLVE, 8'd99, 8'd255, '0, '0, '0, '0);
    send_word(MODE_CLEAR, 8'd255, 8'd0, '0, '0, '0, '0);
    drain();

    foreach (widths[p]) begin
      reg_write(3'd0, {23'd0, widths[p]});
      if (p == 0) hold_req = 1;
      for (int i = 0; i < 175; i++) random_word();
      drain();
    end

    if (pixels.errors == 0 && pixels.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pixels.owed.size() != 0)
        $display("%0t: %0d color words never arrived", $realtime, pixels.owed.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
